/* rtl/core/pcodec_pkg.sv */
package pcodec_pkg;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  localparam logic [63:0] MASK_LOW_RST  = 64'h0000_8000_0000_0000;
  localparam logic [63:0] MASK_HIGH_RST = 64'h0;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    REG_DIRECTION = 2'd0,
    REG_PLUS_MODE = 2'd1,
    REG_MASK_LOW  = 2'd2,
    REG_MASK_HIGH = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_last;
  } out_item_t;

  // Up to three result bytes caused by one input item.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    logic            last;
  } qent_t;

  // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_upper(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'h0, v};
    end else begin
      r = 8'h37 + {4'h0, v};
    end
    return r;
  endfunction

  function automatic logic fixed_safe(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_DOT || c == CH_DASH;
  endfunction

endpackage

/* rtl/core/pcodec_front.sv */
module pcodec_front import pcodec_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  in_item_t    in_data,
  output logic        in_full,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [63:0] cfg_wdata,
  input  logic        q_full,
  output logic        q_push,
  output qent_t       q_wdata
);

  logic        dir_r;
  logic        plus_r;
  logic [63:0] mask_lo_r;
  logic [63:0] mask_hi_r;
  esc_phase_t  phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;

  logic [7:0]  bin;
  logic [7:0]  bd;
  logic [4:0]  hv;
  logic [4:0]  hh;
  logic        safe;
  logic        accept;
  logic [1:0]  n;
  qent_t       ent;

  always_comb begin
    bin  = in_data.in_byte;
    bd   = (plus_r && bin == CH_PLUS) ? CH_SPACE : bin;
    hv   = hex_val(bd);
    hh   = hex_val(held_r);
    safe = fixed_safe(bin) ||
           (!bin[7] && (bin[6] ? mask_hi_r[bin[5:0]] : mask_lo_r[bin[5:0]]));
    ent       = '0;
    n         = '0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (!dir_r) begin
      if (plus_r && bin == CH_SPACE) begin
        ent.bytes[0] = CH_PLUS;
        n = 2'd1;
      end else if (safe) begin
        ent.bytes[0] = bin;
        n = 2'd1;
      end else begin
        ent.bytes[0] = CH_PCT;
        ent.bytes[1] = hex_upper(bin[7:4]);
        ent.bytes[2] = hex_upper(bin[3:0]);
        n = 2'd3;
      end
    end else begin
      unique case (phase_r)
        ESC_PCT: begin
          if (hv[4]) begin
            held_nxt  = bd;
            phase_nxt = ESC_DIGIT;
          end else if (bd == CH_PCT) begin
            ent.bytes[n] = CH_PCT;
            n = n + 2'd1;
          end else begin
            ent.bytes[n] = CH_PCT;
            n = n + 2'd1;
            ent.bytes[n] = bd;
            n = n + 2'd1;
            phase_nxt = ESC_NONE;
          end
        end
        ESC_DIGIT: begin
          if (hv[4]) begin
            ent.bytes[n] = {hh[3:0], hv[3:0]};
            n = n + 2'd1;
            phase_nxt = ESC_NONE;
          end else if (bd == CH_PCT) begin
            ent.bytes[n] = CH_PCT;
            n = n + 2'd1;
            ent.bytes[n] = held_r;
            n = n + 2'd1;
            phase_nxt = ESC_PCT;
          end else begin
            ent.bytes[n] = CH_PCT;
            n = n + 2'd1;
            ent.bytes[n] = held_r;
            n = n + 2'd1;
            ent.bytes[n] = bd;
            n = n + 2'd1;
            phase_nxt = ESC_NONE;
          end
          if (phase_nxt != ESC_DIGIT) begin
            held_nxt = '0;
          end
        end
        default: begin
          if (bd == CH_PCT) begin
            phase_nxt = ESC_PCT;
          end else begin
            ent.bytes[n] = bd;
            n = n + 2'd1;
            phase_nxt = ESC_NONE;
          end
        end
      endcase
      if (in_data.in_last) begin
        if (phase_nxt == ESC_PCT) begin
          ent.bytes[n] = CH_PCT;
          n = n + 2'd1;
        end else if (phase_nxt == ESC_DIGIT) begin
          ent.bytes[n] = CH_PCT;
          n = n + 2'd1;
          ent.bytes[n] = held_nxt;
          n = n + 2'd1;
        end
        phase_nxt = ESC_NONE;
        held_nxt  = '0;
      end
    end
    ent.count = n;
    ent.last  = in_data.in_last;
  end

  assign accept  = in_push && !q_full;
  assign in_full = q_full;
  assign q_push  = accept && (n != 2'd0);
  assign q_wdata = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r     <= 1'b0;
      plus_r    <= 1'b0;
      mask_lo_r <= MASK_LOW_RST;
      mask_hi_r <= MASK_HIGH_RST;
      phase_r   <= ESC_NONE;
      held_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_idx))
          REG_DIRECTION: dir_r     <= cfg_wdata[0];
          REG_PLUS_MODE: plus_r    <= cfg_wdata[0];
          REG_MASK_LOW:  mask_lo_r <= cfg_wdata;
          REG_MASK_HIGH: mask_hi_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cfg_we && cfg_reg_t'(cfg_idx) == REG_DIRECTION) begin
        phase_r <= ESC_NONE;
        held_r  <= '0;
      end else if (accept) begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
      end
    end
  end

endmodule

/* rtl/core/pcodec_queue.sv */
module pcodec_queue import pcodec_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t wdata,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output qent_t head
);

  qent_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   cnt_r;
  logic           do_push;
  logic           do_pop;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/pcodec_back.sv */
module pcodec_back import pcodec_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  qent_t     q_head,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       fin;
  logic       take;

  always_comb begin
    fin           = (idx_r == q_head.count - 2'd1);
    take          = (!out_valid_r || out_pop) && !q_empty;
    q_pop         = take && fin;
    out_valid_nxt = take || (out_valid_r && !out_pop);
    idx_nxt       = idx_r;
    out_item_nxt  = out_item_r;
    if (take) begin
      out_item_nxt.out_byte    = q_head.bytes[idx_r];
      out_item_nxt.run_last    = fin;
      out_item_nxt.string_last = fin && q_head.last;
      idx_nxt = fin ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_item_r;

endmodule

/* rtl/core/percent_codec_top.sv */
// URL percent codec for a byte stream.
// Input channel: push an item (one source byte and its end-of-string flag) while
// in_full is low. Result channel: while out_empty is low, out_data holds the oldest
// result byte with its run_last and string_last flags; pop takes it.
// Configuration: cfg_we writes cfg_wdata into register cfg_idx (0 direction,
// 1 plus mode, 2 low safe mask, 3 high safe mask); write only while the block is idle.
// The front stage classifies each item in its accept cycle and queues up to three
// result bytes in a four-entry queue. The back stage sends one byte per cycle while
// bytes wait and the receiver pops each one. The first result of an item passes through
// the queue and the output register before it shows, when nothing waits ahead of it.
// The result channel carries one result byte per cycle while the receiver pops, so an
// item that expands to three bytes holds it for all three; the input keeps taking items
// until the queue fills.
// Reset empties the queue and the output register, clears the escape state and sets the registers
// to their defaults. When the receiver stalls, the output holds and the queue fills,
// after which in_full rises; no item is lost.
module percent_codec_top import pcodec_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  in_item_t    in_data,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [63:0] cfg_wdata
);

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  qent_t q_wdata;
  qent_t q_head;

  pcodec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  pcodec_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .head  (q_head)
  );

  pcodec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

/* rtl/core/pcodec_checker.sv */
module pcodec_checker import pcodec_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input out_item_t   out_data
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  // Reset leaves the input open.
  a_reset_open: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input blocked after reset");

  // A waiting result that is not taken stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("stalled result changed");

  // The final byte of a string always closes the run of its item.
  a_last_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.string_last) |-> out_data.run_last)
    else $error("string end without run end");

endmodule

bind percent_codec_top pcodec_checker u_chk (.*);
